FILE: hw/rtl/spff_pkg.sv
// Package for the smallest prime factor factorizer: widths, table size,
// sequencer step codes, control word layout and the microprogram ROM.
// No dependencies.
`timescale 1ns / 1ps

package spff_pkg;

  // table size and field widths
  localparam int VALUE_LIMIT = 131072;
  localparam int ADDR_W      = $clog2(VALUE_LIMIT);
  localparam int VALUE_W     = 17;
  localparam int PRIME_W     = 17;
  localparam int EXP_W       = 5;
  localparam int STEP_W      = 4;

  // sequencer steps
  localparam logic [STEP_W-1:0] ST_SV_INIT = 4'd0;
  localparam logic [STEP_W-1:0] ST_SV_ROW  = 4'd1;
  localparam logic [STEP_W-1:0] ST_SV_WR   = 4'd2;
  localparam logic [STEP_W-1:0] ST_SV_NEXT = 4'd3;
  localparam logic [STEP_W-1:0] ST_IDLE    = 4'd4;
  localparam logic [STEP_W-1:0] ST_TEST    = 4'd5;
  localparam logic [STEP_W-1:0] ST_FIRST   = 4'd6;
  localparam logic [STEP_W-1:0] ST_DIVGO   = 4'd7;
  localparam logic [STEP_W-1:0] ST_DIVWAIT = 4'd8;
  localparam logic [STEP_W-1:0] ST_RD      = 4'd9;
  localparam logic [STEP_W-1:0] ST_CHK     = 4'd10;
  localparam logic [STEP_W-1:0] ST_EMIT    = 4'd11;
  localparam logic [STEP_W-1:0] ST_EMIT2   = 4'd12;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_SV_INIT,
    OP_SV_ROW,
    OP_SV_WR,
    OP_SV_NEXT,
    OP_ACCEPT,
    OP_FIRST,
    OP_DIVGO,
    OP_DIVWAIT,
    OP_EMIT
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_ROW_END,
    COND_SIEVE_DONE,
    COND_IN_XFER,
    COND_X_ONE,
    COND_DIV_DONE,
    COND_NEW_PRIME,
    COND_OUT_FREE
  } cond_e;

  // one control word
  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] tgt_t;
    logic [STEP_W-1:0] tgt_f;
  } ucode_t;

  // microprogram: sieve fill from the top divisor down, then factoring loop
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      ST_SV_INIT: w = '{OP_SV_INIT, COND_ALWAYS,     ST_SV_ROW,  ST_SV_ROW};
      ST_SV_ROW:  w = '{OP_SV_ROW,  COND_ALWAYS,     ST_SV_WR,   ST_SV_WR};
      ST_SV_WR:   w = '{OP_SV_WR,   COND_ROW_END,    ST_SV_NEXT, ST_SV_WR};
      ST_SV_NEXT: w = '{OP_SV_NEXT, COND_SIEVE_DONE, ST_IDLE,    ST_SV_ROW};
      ST_IDLE:    w = '{OP_ACCEPT,  COND_IN_XFER,    ST_TEST,    ST_IDLE};
      ST_TEST:    w = '{OP_NOP,     COND_X_ONE,      ST_EMIT,    ST_FIRST};
      ST_FIRST:   w = '{OP_FIRST,   COND_ALWAYS,     ST_DIVGO,   ST_DIVGO};
      ST_DIVGO:   w = '{OP_DIVGO,   COND_ALWAYS,     ST_DIVWAIT, ST_DIVWAIT};
      ST_DIVWAIT: w = '{OP_DIVWAIT, COND_DIV_DONE,   ST_RD,      ST_DIVWAIT};
      ST_RD:      w = '{OP_NOP,     COND_ALWAYS,     ST_CHK,     ST_CHK};
      ST_CHK:     w = '{OP_NOP,     COND_NEW_PRIME,  ST_EMIT,    ST_DIVGO};
      ST_EMIT:    w = '{OP_EMIT,    COND_OUT_FREE,   ST_EMIT2,   ST_EMIT};
      ST_EMIT2:   w = '{OP_NOP,     COND_X_ONE,      ST_IDLE,    ST_FIRST};
      default:    w = '{OP_NOP,     COND_ALWAYS,     ST_IDLE,    ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/spff_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on spff_pkg for the operand width.
`timescale 1ns / 1ps

module spff_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [spff_pkg::VALUE_W-1:0] dividend_i,
  input  logic [spff_pkg::VALUE_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [spff_pkg::VALUE_W-1:0] quotient_o
);

  localparam int W   = spff_pkg::VALUE_W;
  localparam int CW  = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  // one shift and trial subtract
  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/smallest_prime_factor_factorizer.sv
// Top level of the smallest prime factor factorizer: microcoded sequencer,
// smallest-prime-factor table memory, result register.
// Depends on spff_pkg and spff_div.
`timescale 1ns / 1ps

// channel   dir  payload (lowest bit up)                       marker
// s_axis    in   tdata: value[16:0], zero pad to 24 bits       -
// m_axis    out  tdata: prime_factor[16:0], exponent[21:17]    tlast: last_factor
//
// After reset the sieve fills the table, one table write per cycle, row by row
// for each divisor from VALUE_LIMIT-1 down to 2; input is not ready meanwhile.
// A value is then divided by each of its prime factors in turn in the
// bit-serial divider; a value below two skips the divider. The result register
// lets the next value be accepted while a result waits; a stalled output holds
// the sequencer at its emit step.

module smallest_prime_factor_factorizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // value[16:0], zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // prime_factor[16:0], exponent[21:17], zero pad
  output logic        m_axis_tlast_o    // last_factor
);

  localparam int AW = spff_pkg::ADDR_W;
  localparam int VW = spff_pkg::VALUE_W;
  localparam int PW = spff_pkg::PRIME_W;
  localparam int EW = spff_pkg::EXP_W;
  localparam int SW = spff_pkg::STEP_W;

  logic [SW-1:0]   pc_q, pc_d;
  spff_pkg::ucode_t uw;
  logic [AW-1:0]   i_q, i_d;
  logic [AW-1:0]   j_q, j_d;
  logic [AW:0]     nxt;
  logic [VW-1:0]   x_q, x_d;
  logic [PW-1:0]   p_q, p_d;
  logic [EW-1:0]   c_q, c_d;
  logic            out_valid_q, out_valid_d;
  logic [PW-1:0]   out_prime_q, out_prime_d;
  logic [EW-1:0]   out_exp_q, out_exp_d;
  logic            out_last_q, out_last_d;
  logic            cond;
  logic            in_xfer;
  logic            out_free;
  logic            in_small;
  logic [VW-1:0]   in_value;
  logic            we;
  logic [PW-1:0]   rdata_q;
  logic            div_start;
  logic            div_done;
  logic [VW-1:0]   div_quo;

  logic [PW-1:0] mem [spff_pkg::VALUE_LIMIT];

  assign uw       = spff_pkg::ucode_rom(pc_q);
  assign nxt      = {1'b0, j_q} + {1'b0, i_q};
  assign in_value = s_axis_tdata_i[VW-1:0];
  assign in_small = (in_value < VW'(2)) || (32'(in_value) >= 32'(spff_pkg::VALUE_LIMIT));
  assign s_axis_tready_o = (uw.op == spff_pkg::OP_ACCEPT);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign we        = (uw.op == spff_pkg::OP_SV_WR);
  assign div_start = (uw.op == spff_pkg::OP_DIVGO);

  // jump condition select
  always_comb begin
    case (uw.cond)
      spff_pkg::COND_ALWAYS:     cond = 1'b1;
      spff_pkg::COND_ROW_END:    cond = (nxt >= (AW+1)'(spff_pkg::VALUE_LIMIT));
      spff_pkg::COND_SIEVE_DONE: cond = (i_q == AW'(2));
      spff_pkg::COND_IN_XFER:    cond = in_xfer;
      spff_pkg::COND_X_ONE:      cond = (x_q == VW'(1));
      spff_pkg::COND_DIV_DONE:   cond = div_done;
      spff_pkg::COND_NEW_PRIME:  cond = (x_q == VW'(1)) || (rdata_q != p_q);
      spff_pkg::COND_OUT_FREE:   cond = out_free;
      default:                   cond = 1'b1;
    endcase
  end

  // step counter and datapath operations
  always_comb begin
    pc_d        = cond ? uw.tgt_t : uw.tgt_f;
    i_d         = i_q;
    j_d         = j_q;
    x_d         = x_q;
    p_d         = p_q;
    c_d         = c_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_prime_d = out_prime_q;
    out_exp_d   = out_exp_q;
    out_last_d  = out_last_q;
    case (uw.op)
      spff_pkg::OP_SV_INIT: i_d = AW'(spff_pkg::VALUE_LIMIT - 1);
      spff_pkg::OP_SV_ROW:  j_d = i_q;
      spff_pkg::OP_SV_WR:   j_d = nxt[AW-1:0];
      spff_pkg::OP_SV_NEXT: i_d = i_q - 1'b1;
      spff_pkg::OP_ACCEPT: begin
        if (in_xfer) begin
          x_d = in_small ? VW'(1) : in_value;
          p_d = '0;
          c_d = '0;
        end
      end
      spff_pkg::OP_FIRST: begin
        p_d = rdata_q;
        c_d = '0;
      end
      spff_pkg::OP_DIVWAIT: begin
        if (div_done) begin
          x_d = div_quo;
          c_d = c_q + 1'b1;
        end
      end
      spff_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_prime_d = p_q;
          out_exp_d   = c_q;
          out_last_d  = (x_q == VW'(1));
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= spff_pkg::ST_SV_INIT;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    x_q         <= x_d;
    p_q         <= p_d;
    c_q         <= c_d;
    out_prime_q <= out_prime_d;
    out_exp_q   <= out_exp_d;
    out_last_q  <= out_last_d;
  end

  // smallest prime factor table, last writer per entry is its least divisor
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[j_q] <= PW'(i_q);
    end
    rdata_q <= mem[AW'(x_q)];
  end

  // exact division of the value by its current prime
  spff_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (x_q),
    .divisor_i  (p_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // result channel
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_exp_q, out_prime_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
